### src/omtw_pkg.sv
package omtw_pkg;

	localparam int CordMax = 24;
	localparam int XW = 34;
	localparam int ZW = 33;
	localparam int VW = 45;
	localparam int MW = 44;
	localparam int NW = 54;
	localparam int DW = 41;
	localparam int QB = 11;
	localparam int IdxW = 8;

	localparam logic signed [XW-1:0] CORD_GAIN = 34'sd652032874;
	localparam logic [24:0] SPEED_SCALE = 25'd32768000;

	localparam logic [IdxW-1:0] REG_OFFSET = 8'd0;
	localparam logic [IdxW-1:0] REG_BASE   = 8'd1;
	localparam logic [IdxW-1:0] REG_SPEED  = 8'd2;
	localparam logic [IdxW-1:0] REG_PWM    = 8'd3;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cord_t;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [QB-1:0] q;
	} div_t;

	typedef struct packed {
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] rot_rate;
	} cmd_t;

	function automatic logic [31:0] atan_at(input int idx);
		logic [31:0] r;
		case (idx)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051D;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2F9;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

### src/omtw_if.sv
interface omtw_cmd_if;
	logic valid;
	logic ready;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic signed [15:0] rot_rate;
	logic [15:0] heading;
	modport source(output valid, vel_x, vel_y, rot_rate, heading, input ready);
	modport sink(input valid, vel_x, vel_y, rot_rate, heading, output ready);
endinterface

interface omtw_wheel_if;
	logic valid;
	logic ready;
	logic [9:0] duty_one;
	logic [9:0] duty_two;
	logic [9:0] duty_three;
	logic fwd_one;
	logic fwd_two;
	logic fwd_three;
	modport source(output valid, duty_one, duty_two, duty_three, fwd_one, fwd_two, fwd_three,
		input ready);
	modport sink(input valid, duty_one, duty_two, duty_three, fwd_one, fwd_two, fwd_three,
		output ready);
endinterface

interface omtw_cfg_if;
	logic valid;
	logic ready;
	logic [omtw_pkg::IdxW-1:0] index;
	logic [15:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### src/omtw_cordic_cell.sv
module omtw_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  logic            en,
	input  omtw_pkg::cord_t a,
	output omtw_pkg::cord_t b
);

	omtw_pkg::cord_t st_q;
	logic signed [omtw_pkg::XW-1:0] dx;
	logic signed [omtw_pkg::XW-1:0] dy;
	logic signed [omtw_pkg::ZW-1:0] at;

	assign dx = a.y >>> IDX;
	assign dy = a.x >>> IDX;
	assign at = signed'({1'b0, omtw_pkg::atan_at(IDX)});

	always_ff @(posedge clk) begin
		if (en) begin
			if (!a.z[omtw_pkg::ZW-1]) begin
				st_q.x <= a.x - dx;
				st_q.y <= a.y + dy;
				st_q.z <= a.z - at;
			end else begin
				st_q.x <= a.x + dx;
				st_q.y <= a.y - dy;
				st_q.z <= a.z + at;
			end
		end
	end

	assign b = st_q;

endmodule

### src/omtw_div_cell.sv
module omtw_div_cell #(
	parameter int K = 0
) (
	input  logic                     clk,
	input  logic                     en,
	input  omtw_pkg::div_t           a,
	input  logic [omtw_pkg::DW-1:0]  den,
	output omtw_pkg::div_t           b
);

	omtw_pkg::div_t st_q;
	logic [omtw_pkg::NW-1:0] trial;

	assign trial = omtw_pkg::NW'(den) << K;

	always_ff @(posedge clk) begin
		if (en) begin
			if (a.rem >= trial) begin
				st_q.rem <= a.rem - trial;
				st_q.q   <= a.q | (omtw_pkg::QB'(1) << K);
			end else begin
				st_q <= a;
			end
		end
	end

	assign b = st_q;

endmodule

### src/omni_three_wheel_pwm_mixer.sv
// Three-wheel omni-drive mixer: each command (vel_x, vel_y, rot_rate, heading) yields one
// result with the PWM duty and direction of the three wheels. A new command is taken every
// cycle while the skid register is empty, and each command passes the row of CORDIC cells
// (one rotation per cell for the three wheel angles) and the row of eleven restoring
// divider cells that scale each speed to pwm_max. The registers are read at several pipeline
// stages, so configuration writes must only be made while no command is in flight.
module omni_three_wheel_pwm_mixer #(
	parameter int TRIG_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	omtw_cmd_if.sink     cmd,
	omtw_wheel_if.source wheel,
	omtw_cfg_if.sink     cfg
);

	localparam int NC = (TRIG_BITS > omtw_pkg::CordMax) ? omtw_pkg::CordMax :
		((TRIG_BITS < 0) ? 0 : TRIG_BITS);
	localparam int QB = omtw_pkg::QB;
	localparam logic [2:0] NEG_X = 3'b101;
	localparam logic [2:0] NEG_Y = 3'b001;

	typedef struct packed {
		omtw_pkg::cord_t c;
		logic            neg;
	} fold_t;

	typedef struct packed {
		logic [2:0][9:0] duty;
		logic [2:0]      fwd;
	} res_t;

	function automatic fold_t fold(input logic [15:0] ang);
		logic signed [16:0] s;
		fold_t r;
		s = signed'({ang[15], ang});
		r.neg = 1'b0;
		if (s > 17'sd16384) begin
			s = s - 17'sd32768;
			r.neg = 1'b1;
		end else if (s < -17'sd16384) begin
			s = s + 17'sd32768;
			r.neg = 1'b1;
		end
		r.c.x = omtw_pkg::CORD_GAIN;
		r.c.y = '0;
		r.c.z = signed'({s, 16'b0});
		return r;
	endfunction

	function automatic logic signed [15:0] to_q15(input logic signed [omtw_pkg::XW:0] v);
		logic signed [omtw_pkg::XW:0] t;
		logic signed [15:0] r;
		t = (v + signed'((omtw_pkg::XW+1)'(16384))) >>> 15;
		if (t > signed'((omtw_pkg::XW+1)'(32767))) begin
			r = 16'sh7FFF;
		end else if (t < -signed'((omtw_pkg::XW+1)'(32768))) begin
			r = 16'sh8000;
		end else begin
			r = t[15:0];
		end
		return r;
	endfunction

	logic [15:0] off_q;
	logic [9:0] base_q;
	logic [15:0] smax_q;
	logic [9:0] pwm_q;
	logic [omtw_pkg::DW-1:0] den_q;

	logic en;
	logic acc;
	logic [2:0][15:0] ang;
	fold_t fd [3];

	omtw_pkg::cord_t c0_s [3];
	omtw_pkg::cord_t cw [NC+1][3];
	logic neg_s [NC+1][3];
	omtw_pkg::cmd_t pc_s [NC+1];
	logic vc_s [NC+1];

	logic signed [16:0] kx_s1 [3];
	logic signed [16:0] ky_s1 [3];
	omtw_pkg::cmd_t p_s1;
	logic v_s1;

	logic signed [32:0] px_s2 [3];
	logic signed [32:0] py_s2 [3];
	logic signed [26:0] lw_s2;
	logic v_s2;

	logic signed [33:0] sum_s3 [3];
	logic signed [26:0] lw_s3;
	logic v_s3;

	logic signed [omtw_pkg::VW-1:0] sp_s4 [3];
	logic v_s4;

	logic [omtw_pkg::NW-1:0] n_s5 [3];
	logic [2:0] fwd_s5;
	logic v_s5;

	omtw_pkg::div_t d0_s6 [3];
	omtw_pkg::div_t dw [QB+1][3];
	logic [2:0] sat_s [QB+1];
	logic [2:0] fwd_s [QB+1];
	logic vd_s [QB+1];

	res_t res_s7;
	logic v_s7;

	res_t out_q;
	logic out_v_q;
	res_t skid_q;
	logic skid_v_q;
	logic take;
	logic prod;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= 16'd5461;
			base_q <= 10'd100;
			smax_q <= 16'd1000;
			pwm_q  <= 10'd255;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				omtw_pkg::REG_OFFSET: off_q <= cfg.data;
				omtw_pkg::REG_BASE:   base_q <= cfg.data[9:0];
				omtw_pkg::REG_SPEED:  smax_q <= cfg.data;
				omtw_pkg::REG_PWM:    pwm_q <= cfg.data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		den_q <= omtw_pkg::DW'((smax_q == '0) ? 16'd1 : smax_q) *
			omtw_pkg::DW'(omtw_pkg::SPEED_SCALE);
	end

	assign en = !skid_v_q;
	assign cmd.ready = en;
	assign acc = cmd.valid && en;
	assign prod = en && v_s7;

	assign ang[0] = off_q + cmd.heading;
	assign ang[1] = cmd.heading;
	assign ang[2] = off_q - cmd.heading;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			fd[l] = fold(ang[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NC; i++) begin
				vc_s[i] <= 1'b0;
			end
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i <= QB; i++) begin
				vd_s[i] <= 1'b0;
			end
			v_s7 <= 1'b0;
		end else if (en) begin
			vc_s[0] <= acc;
			for (int i = 0; i < NC; i++) begin
				vc_s[i+1] <= vc_s[i];
			end
			v_s1 <= vc_s[NC];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			vd_s[0] <= v_s5;
			for (int i = 0; i < QB; i++) begin
				vd_s[i+1] <= vd_s[i];
			end
			v_s7 <= vd_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				c0_s[l] <= fd[l].c;
				neg_s[0][l] <= fd[l].neg;
			end
			pc_s[0] <= '{vel_x: cmd.vel_x, vel_y: cmd.vel_y, rot_rate: cmd.rot_rate};
			for (int i = 0; i < NC; i++) begin
				pc_s[i+1] <= pc_s[i];
				for (int l = 0; l < 3; l++) begin
					neg_s[i+1][l] <= neg_s[i][l];
				end
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		assign cw[0][l] = c0_s[l];
		for (genvar i = 0; i < NC; i++) begin : g_cord
			omtw_cordic_cell #(.IDX(i)) u_cell (
				.clk(clk),
				.en (en),
				.a  (cw[i][l]),
				.b  (cw[i+1][l])
			);
		end
		assign dw[0][l] = d0_s6[l];
		for (genvar j = 0; j < QB; j++) begin : g_div
			omtw_div_cell #(.K(QB-1-j)) u_cell (
				.clk(clk),
				.en (en),
				.a  (dw[j][l]),
				.den(den_q),
				.b  (dw[j+1][l])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				logic signed [omtw_pkg::XW:0] xs;
				logic signed [omtw_pkg::XW:0] ys;
				logic signed [15:0] cq;
				logic signed [15:0] sq;
				xs = neg_s[NC][l] ? -(omtw_pkg::XW+1)'(cw[NC][l].x)
					: (omtw_pkg::XW+1)'(cw[NC][l].x);
				ys = neg_s[NC][l] ? -(omtw_pkg::XW+1)'(cw[NC][l].y)
					: (omtw_pkg::XW+1)'(cw[NC][l].y);
				cq = to_q15(xs);
				sq = to_q15(ys);
				kx_s1[l] <= NEG_X[l] ? -17'(cq) : 17'(cq);
				ky_s1[l] <= NEG_Y[l] ? -17'(sq) : 17'(sq);
			end
			p_s1 <= pc_s[NC];

			for (int l = 0; l < 3; l++) begin
				px_s2[l] <= kx_s1[l] * p_s1.vel_x;
				py_s2[l] <= ky_s1[l] * p_s1.vel_y;
			end
			lw_s2 <= signed'({1'b0, base_q}) * p_s1.rot_rate;

			for (int l = 0; l < 3; l++) begin
				sum_s3[l] <= 34'(px_s2[l]) + 34'(py_s2[l]);
			end
			lw_s3 <= lw_s2;

			for (int l = 0; l < 3; l++) begin
				sp_s4[l] <= omtw_pkg::VW'(sum_s3[l]) * signed'(omtw_pkg::VW'(1000))
					+ (omtw_pkg::VW'(lw_s3) <<< 15);
			end

			for (int l = 0; l < 3; l++) begin
				logic [omtw_pkg::MW-1:0] mag;
				mag = sp_s4[l][omtw_pkg::VW-1] ? omtw_pkg::MW'(-sp_s4[l])
					: omtw_pkg::MW'(sp_s4[l]);
				n_s5[l] <= mag * pwm_q;
				fwd_s5[l] <= !sp_s4[l][omtw_pkg::VW-1] && (sp_s4[l] != '0);
			end

			for (int l = 0; l < 3; l++) begin
				d0_s6[l].rem <= n_s5[l];
				d0_s6[l].q <= '0;
				sat_s[0][l] <= n_s5[l] >= (omtw_pkg::NW'(den_q) << QB);
			end
			fwd_s[0] <= fwd_s5;
			for (int i = 0; i < QB; i++) begin
				sat_s[i+1] <= sat_s[i];
				fwd_s[i+1] <= fwd_s[i];
			end

			for (int l = 0; l < 3; l++) begin
				if (sat_s[QB][l] || (dw[QB][l].q > QB'(pwm_q))) begin
					res_s7.duty[l] <= pwm_q;
				end else begin
					res_s7.duty[l] <= dw[QB][l].q[9:0];
				end
			end
			res_s7.fwd <= fwd_s[QB];
		end
	end

	assign take = !out_v_q || wheel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= prod;
			end
		end else if (prod) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_v_q ? skid_q : res_s7;
		end else if (prod) begin
			skid_q <= res_s7;
		end
	end

	assign wheel.valid = out_v_q;
	assign wheel.duty_one = out_q.duty[0];
	assign wheel.duty_two = out_q.duty[1];
	assign wheel.duty_three = out_q.duty[2];
	assign wheel.fwd_one = out_q.fwd[0];
	assign wheel.fwd_two = out_q.fwd[1];
	assign wheel.fwd_three = out_q.fwd[2];

	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("Skid entry held without an output entry.");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !wheel.ready |=> skid_v_q)
		else $error("Skid entry lost while the output stalled.");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !wheel.ready))
		else $error("Skid filled while the output could transfer.");

endmodule

### dv/omtw_tb_scoreboard.sv
class wheel_scoreboard;
	typedef struct packed {
		logic [9:0] duty_one;
		logic [9:0] duty_two;
		logic [9:0] duty_three;
		logic fwd_one;
		logic fwd_two;
		logic fwd_three;
	} wheel_out_t;

	logic [15:0] offset_angle;
	logic [9:0] base_mm;
	logic [15:0] speed_full;
	logic [9:0] duty_full;
	wheel_out_t pending[$];
	int errors;

	function new();
		offset_angle = 16'd5461;
		base_mm = 10'd100;
		speed_full = 16'd1000;
		duty_full = 10'd255;
		errors = 0;
	endfunction

	function void write_reg(logic [7:0] idx, logic [15:0] data);
		case (idx)
			omtw_pkg::REG_OFFSET: offset_angle = data;
			omtw_pkg::REG_BASE: base_mm = data[9:0];
			omtw_pkg::REG_SPEED: speed_full = data;
			omtw_pkg::REG_PWM: duty_full = data[9:0];
			default: ;
		endcase
	endfunction

	function longint floor_shift(longint v, int k);
		return v >>> k;
	endfunction

	function longint round_q15(longint v);
		longint r;
		r = (v + (64'sd1 <<< 14)) >>> 15;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r;
	endfunction

	function void rotate(logic [15:0] ang, output longint c, output longint s);
		longint a, x, y, z, dx, dy;
		bit neg;
		int n;
		a = $signed(ang);
		neg = 0;
		n = 16;
		if (a > 16384) begin
			a -= 32768;
			neg = 1;
		end else if (a < -16384) begin
			a += 32768;
			neg = 1;
		end
		x = 652032874;
		y = 0;
		z = a * 65536;
		for (int i = 0; i < n; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(omtw_pkg::atan_at(i));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(omtw_pkg::atan_at(i));
			end
		end
		if (neg) begin
			x = -x;
			y = -y;
		end
		c = round_q15(x);
		s = round_q15(y);
	endfunction

	function void scale(longint v, output logic [9:0] duty, output logic fwd);
		longint mag, den, d;
		mag = v < 0 ? -v : v;
		den = longint'(speed_full == 0 ? 1 : speed_full) * 32768000;
		d = (mag * longint'(duty_full)) / den;
		if (d > duty_full)
			d = duty_full;
		duty = d[9:0];
		fwd = v > 0;
	endfunction

	function void note_command(logic signed [15:0] vx, logic signed [15:0] vy,
		logic signed [15:0] w, logic [15:0] h);
		longint c1, s1, c2, s2, c3, s3, lw, v1, v2, v3;
		wheel_out_t e;
		rotate(offset_angle + h, c1, s1);
		rotate(h, c2, s2);
		rotate(offset_angle - h, c3, s3);
		lw = 32768 * longint'(base_mm) * longint'(w);
		v1 = 1000 * (-c1 * vx - s1 * vy) + lw;
		v2 = 1000 * (c2 * vx + s2 * vy) + lw;
		v3 = 1000 * (-c3 * vx + s3 * vy) + lw;
		scale(v1, e.duty_one, e.fwd_one);
		scale(v2, e.duty_two, e.fwd_two);
		scale(v3, e.duty_three, e.fwd_three);
		pending.push_back(e);
	endfunction

	task report(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	task check_result(wheel_out_t got);
		wheel_out_t e;
		if (pending.size() == 0) begin
			report("unexpected wheel transfer");
			return;
		end
		e = pending.pop_front();
		if (got.duty_one !== e.duty_one)
			report($sformatf("duty_one %0d exp %0d", got.duty_one, e.duty_one));
		if (got.duty_two !== e.duty_two)
			report($sformatf("duty_two %0d exp %0d", got.duty_two, e.duty_two));
		if (got.duty_three !== e.duty_three)
			report($sformatf("duty_three %0d exp %0d", got.duty_three, e.duty_three));
		if (got.fwd_one !== e.fwd_one)
			report($sformatf("fwd_one %0d exp %0d", got.fwd_one, e.fwd_one));
		if (got.fwd_two !== e.fwd_two)
			report($sformatf("fwd_two %0d exp %0d", got.fwd_two, e.fwd_two));
		if (got.fwd_three !== e.fwd_three)
			report($sformatf("fwd_three %0d exp %0d", got.fwd_three, e.fwd_three));
	endtask
endclass

### dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	omtw_cmd_if cmd();
	omtw_wheel_if wheel();
	omtw_cfg_if cfg();
	wheel_scoreboard sb = new();
	bit quiet = 0;
	int hold_off = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	omni_three_wheel_pwm_mixer dut(.clk(clk), .arst_n(arst_n), .cmd(cmd), .wheel(wheel),
		.cfg(cfg));

	initial begin
		cmd.valid = 0;
		cmd.vel_x = 0;
		cmd.vel_y = 0;
		cmd.rot_rate = 0;
		cmd.heading = 0;
		cfg.valid = 0;
		cfg.index = 0;
		cfg.data = 0;
		wheel.ready = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("tb failed");
			$finish;
		end
		if (arst_n && wheel.valid && wheel.ready)
			sb.check_result({wheel.duty_one, wheel.duty_two, wheel.duty_three,
				wheel.fwd_one, wheel.fwd_two, wheel.fwd_three});
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				wheel.ready <= 0;
				hold_off--;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 7);
				wheel.ready <= 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				wheel.ready <= 1;
			end
		end
	end

	task automatic write_cfg(logic [7:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic send_cmd(logic [15:0] vx, logic [15:0] vy, logic [15:0] w,
		logic [15:0] h);
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 7);
			cmd.valid <= 0;
			repeat (n) @(negedge clk);
		end
		cmd.valid <= 1;
		cmd.vel_x <= vx;
		cmd.vel_y <= vy;
		cmd.rot_rate <= w;
		cmd.heading <= h;
		do @(posedge clk); while (!cmd.ready);
		sb.note_command(vx, vy, w, h);
		@(negedge clk);
	endtask

	task automatic drain();
		cmd.valid <= 0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [15:0] spd[5] = '{16'd1, 16'd1000, 16'd65535, 16'd0, 16'd300};
		logic [15:0] pwm[5] = '{16'd1023, 16'd255, 16'd1, 16'd0, 16'd700};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		send_cmd(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000);
		send_cmd(16'h8000, 16'h8000, 16'h8000, 16'hffff);
		send_cmd(0, 0, 0, 16'h4000);
		send_cmd(0, 0, 0, 16'hc000);
		send_cmd(16'h03e8, 0, 0, 16'h8000);
		send_cmd(0, 16'h03e8, 0, 16'h4001);
		send_cmd(0, 0, 16'h0064, 16'hbfff);
		send_cmd(16'hfc18, 16'h0001, 16'hffff, 16'h2aaa);
		send_cmd(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
		send_cmd(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
		drain();
		hold_off = 300;
		repeat (150) send_cmd(pick16(), pick16(), pick16(), $urandom);
		for (int p = 0; p < 5; p++) begin
			drain();
			write_cfg(omtw_pkg::REG_OFFSET, p == 0 ? 16'h0000 : p == 1 ? 16'hffff : $urandom);
			write_cfg(omtw_pkg::REG_BASE, p == 0 ? 16'h0000 : p == 1 ? 16'h03ff : $urandom);
			write_cfg(omtw_pkg::REG_SPEED, spd[p]);
			write_cfg(omtw_pkg::REG_PWM, pwm[p]);
			write_cfg(8'd4 + p, $urandom);
			if (p == 4)
				quiet = 1;
			repeat (p == 4 ? 160 : 408) send_cmd(pick16(), pick16(), pick16(), $urandom);
		end
		drain();
		if (sb.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
